// ===== src/pgs_pkg.sv =====
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared constants for the polar-method Gaussian sampler.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int UniformBitsDef = 16;
    localparam int CoordBits      = 16;
    localparam int MeanBits       = 16;
    localparam int StdBits        = 15;
    localparam int CfgDataBits    = 16;
    localparam int OutBits        = 24;

    // Q1.30 mantissa, Q1.30 energy
    localparam int EnergyBits     = 31;
    localparam int LogSteps       = 30;
    localparam int Nl2Bits        = 35;
    localparam int GBits          = 32;
    localparam int NumBits        = 62;
    localparam int DivSteps       = 32;
    localparam int SqrtSteps      = 29;
    localparam int ProdBits       = 44;
    localparam int RoundBits      = 19;

    localparam logic [27:0] Ln2Q28 = 28'd186065279;
    localparam logic [30:0] OneQ30 = 31'h4000_0000;

    typedef enum logic [1:0] {
        CFG_MEAN = 2'd0,
        CFG_STD  = 2'd1
    } t_cfg_idx;

endpackage

// ===== src/polar_gaussian_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// polar_gaussian_sampler_unit
// Rejected pairs vanish and produce no result.
// Throughput: one candidate pair per cycle; the whole pipeline holds while
// a result waits on a stalled output.
// Reset clears all valid bits; mean resets to 0 and std_dev to 1.0.
// ----------------------------------------------------------------------------
// Marsaglia polar method in fixed point: squares, energy with reject test,
// 30-stage log2 by repeated squaring, scaled log, 32-stage restoring divider,
// 29-stage square root, scale by std_dev, round, add mean, saturate.
// ----------------------------------------------------------------------------
module polar_gaussian_sampler_unit #(
    parameter int UNIFORM_BITS = pgs_pkg::UniformBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  pgs_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [pgs_pkg::CfgDataBits-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [UNIFORM_BITS-1:0]      i_uniform_a,
    input  logic [UNIFORM_BITS-1:0]      i_uniform_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [pgs_pkg::OutBits-1:0] o_gaussian_sample
);
    import pgs_pkg::*;

    logic w_en;

    // configuration
    logic signed [MeanBits-1:0] r_mean;
    logic [StdBits-1:0]         r_std;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_std  <= StdBits'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEAN: r_mean <= i_cfg_data[MeanBits-1:0];
                CFG_STD:  r_std  <= i_cfg_data[StdBits-1:0];
                default:  ;
            endcase
        end
    end

    // coordinates
    logic [CoordBits-1:0] w_wa, w_wb;
    generate
        if (UNIFORM_BITS >= CoordBits) begin : g_wide
            assign w_wa = i_uniform_a[UNIFORM_BITS-1 -: CoordBits];
            assign w_wb = i_uniform_b[UNIFORM_BITS-1 -: CoordBits];
        end else begin : g_narrow
            assign w_wa = {i_uniform_a, {(CoordBits-UNIFORM_BITS){1'b0}}};
            assign w_wb = {i_uniform_b, {(CoordBits-UNIFORM_BITS){1'b0}}};
        end
    endgenerate

    logic signed [CoordBits-1:0] w_x, w_y;
    assign w_x = $signed({~w_wa[CoordBits-1], w_wa[CoordBits-2:0]});
    assign w_y = $signed({~w_wb[CoordBits-1], w_wb[CoordBits-2:0]});

    // stage 1: squares
    logic                  r_s1_vld, r_s1_xn;
    logic [EnergyBits-1:0] r_s1_x2, r_s1_y2;
    logic signed [2*CoordBits-1:0] w_xx, w_yy;
    assign w_xx = w_x * w_x;
    assign w_yy = w_y * w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
        end
        if (w_en) begin
            r_s1_xn <= w_x[CoordBits-1];
            r_s1_x2 <= w_xx[EnergyBits-1:0];
            r_s1_y2 <= w_yy[EnergyBits-1:0];
        end
    end

    // stage 2: energy and reject
    logic                  r_s2_vld, r_s2_xn;
    logic [EnergyBits-1:0] r_s2_s, r_s2_x2;
    logic [EnergyBits-1:0] w_s;
    assign w_s = r_s1_x2 + r_s1_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld && (w_s != '0) && (w_s <= OneQ30);
        end
        if (w_en) begin
            r_s2_xn <= r_s1_xn;
            r_s2_s  <= w_s;
            r_s2_x2 <= r_s1_x2;
        end
    end

    // stage 3 (log index 0): normalize
    logic                  r_lg_vld [0:LogSteps];
    logic                  r_lg_xn  [0:LogSteps];
    logic [EnergyBits-1:0] r_lg_m   [0:LogSteps];
    logic [LogSteps-1:0]   r_lg_f   [0:LogSteps];
    logic [4:0]            r_lg_e   [0:LogSteps];
    logic [EnergyBits-1:0] r_lg_s   [0:LogSteps];
    logic [EnergyBits-1:0] r_lg_x2  [0:LogSteps];

    logic [4:0] w_e;
    always_comb begin
        w_e = '0;
        for (int i = 0; i < EnergyBits; i++) begin
            if (r_s2_s[i]) w_e = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_lg_vld[0] <= r_s2_vld;
        end
        if (w_en) begin
            r_lg_xn[0] <= r_s2_xn;
            r_lg_m[0]  <= r_s2_s << (5'd30 - w_e);
            r_lg_f[0]  <= '0;
            r_lg_e[0]  <= w_e;
            r_lg_s[0]  <= r_s2_s;
            r_lg_x2[0] <= r_s2_x2;
        end
    end

    // log2 fraction, one bit per stage
    generate
        for (genvar k = 0; k < LogSteps; k++) begin : g_log
            logic [2*EnergyBits-1:0] w_sq;
            logic [EnergyBits:0]     w_t;
            assign w_sq = r_lg_m[k] * r_lg_m[k];
            assign w_t  = w_sq[EnergyBits+30:30];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_lg_vld[k+1] <= 1'b0;
                end else if (w_en) begin
                    r_lg_vld[k+1] <= r_lg_vld[k];
                end
                if (w_en) begin
                    r_lg_xn[k+1] <= r_lg_xn[k];
                    r_lg_m[k+1]  <= w_t[EnergyBits] ? w_t[EnergyBits:1]
                                                    : w_t[EnergyBits-1:0];
                    r_lg_f[k+1]  <= {r_lg_f[k][LogSteps-2:0], w_t[EnergyBits]};
                    r_lg_e[k+1]  <= r_lg_e[k];
                    r_lg_s[k+1]  <= r_lg_s[k];
                    r_lg_x2[k+1] <= r_lg_x2[k];
                end
            end
        end
    endgenerate

    // scaled log: partial products of nl2 * ln2
    logic [Nl2Bits-1:0] w_nl2;
    assign w_nl2 = {5'd30 - r_lg_e[LogSteps], 30'd0} - {5'd0, r_lg_f[LogSteps]};

    logic                  r_g1_vld, r_g1_xn;
    logic [44:0]           r_g1_lo;
    logic [45:0]           r_g1_hi;
    logic [EnergyBits-1:0] r_g1_s, r_g1_x2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_vld <= 1'b0;
        end else if (w_en) begin
            r_g1_vld <= r_lg_vld[LogSteps];
        end
        if (w_en) begin
            r_g1_xn <= r_lg_xn[LogSteps];
            r_g1_lo <= w_nl2[16:0] * Ln2Q28;
            r_g1_hi <= w_nl2[Nl2Bits-1:17] * Ln2Q28;
            r_g1_s  <= r_lg_s[LogSteps];
            r_g1_x2 <= r_lg_x2[LogSteps];
        end
    end

    logic [63:0] w_gsum;
    assign w_gsum = {1'b0, r_g1_hi, 17'd0} + {19'd0, r_g1_lo};

    logic                  r_g2_vld, r_g2_xn;
    logic [GBits-1:0]      r_g2_g;
    logic [EnergyBits-1:0] r_g2_s, r_g2_x2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2_vld <= 1'b0;
        end else if (w_en) begin
            r_g2_vld <= r_g1_vld;
        end
        if (w_en) begin
            r_g2_xn <= r_g1_xn;
            r_g2_g  <= w_gsum[31+GBits-1:31];
            r_g2_s  <= r_g1_s;
            r_g2_x2 <= r_g1_x2;
        end
    end

    // numerator g*x2 loads divider index 0
    logic [GBits+EnergyBits-1:0] w_num;
    assign w_num = r_g2_g * r_g2_x2;

    logic                  r_dv_vld [0:DivSteps];
    logic                  r_dv_xn  [0:DivSteps];
    logic [EnergyBits-1:0] r_dv_rem [0:DivSteps];
    logic [DivSteps-1:0]   r_dv_n   [0:DivSteps];
    logic [DivSteps-1:0]   r_dv_q   [0:DivSteps];
    logic [EnergyBits-1:0] r_dv_d   [0:DivSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_g2_vld;
        end
        if (w_en) begin
            r_dv_xn[0]  <= r_g2_xn;
            r_dv_rem[0] <= {1'b0, w_num[NumBits-1:DivSteps]};
            r_dv_n[0]   <= w_num[DivSteps-1:0];
            r_dv_q[0]   <= '0;
            r_dv_d[0]   <= r_g2_s;
        end
    end

    // restoring divide, one quotient bit per stage
    generate
        for (genvar k = 0; k < DivSteps; k++) begin : g_div
            logic [EnergyBits:0] w_r2, w_df;
            logic                w_ge;
            assign w_r2 = {r_dv_rem[k], r_dv_n[k][DivSteps-1]};
            assign w_df = w_r2 - {1'b0, r_dv_d[k]};
            assign w_ge = w_r2 >= {1'b0, r_dv_d[k]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[k+1] <= 1'b0;
                end else if (w_en) begin
                    r_dv_vld[k+1] <= r_dv_vld[k];
                end
                if (w_en) begin
                    r_dv_xn[k+1]  <= r_dv_xn[k];
                    r_dv_rem[k+1] <= w_ge ? w_df[EnergyBits-1:0] : w_r2[EnergyBits-1:0];
                    r_dv_n[k+1]   <= {r_dv_n[k][DivSteps-2:0], 1'b0};
                    r_dv_q[k+1]   <= {r_dv_q[k][DivSteps-2:0], w_ge};
                    r_dv_d[k+1]   <= r_dv_d[k];
                end
            end
        end
    endgenerate

    // square root of z2 << 26, one root bit per stage
    logic                   r_sq_vld  [0:SqrtSteps];
    logic                   r_sq_xn   [0:SqrtSteps];
    logic [EnergyBits-1:0]  r_sq_rem  [0:SqrtSteps];
    logic [SqrtSteps-1:0]   r_sq_root [0:SqrtSteps];
    logic [2*SqrtSteps-1:0] r_sq_n    [0:SqrtSteps];

    always_comb begin
        r_sq_vld[0]  = r_dv_vld[DivSteps];
        r_sq_xn[0]   = r_dv_xn[DivSteps];
        r_sq_rem[0]  = '0;
        r_sq_root[0] = '0;
        r_sq_n[0]    = {r_dv_q[DivSteps], 26'd0};
    end

    generate
        for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
            logic [EnergyBits+1:0] w_r2, w_t, w_df;
            logic                  w_ge;
            assign w_r2 = {r_sq_rem[k], r_sq_n[k][2*SqrtSteps-1 -: 2]};
            assign w_t  = {2'b00, r_sq_root[k], 2'b01};
            assign w_df = w_r2 - w_t;
            assign w_ge = w_r2 >= w_t;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k+1] <= 1'b0;
                end else if (w_en) begin
                    r_sq_vld[k+1] <= r_sq_vld[k];
                end
                if (w_en) begin
                    r_sq_xn[k+1]   <= r_sq_xn[k];
                    r_sq_rem[k+1]  <= w_ge ? w_df[EnergyBits-1:0] : w_r2[EnergyBits-1:0];
                    r_sq_root[k+1] <= {r_sq_root[k][SqrtSteps-2:0], w_ge};
                    r_sq_n[k+1]    <= {r_sq_n[k][2*SqrtSteps-3:0], 2'b00};
                end
            end
        end
    endgenerate

    // scale by std_dev
    logic                r_p_vld, r_p_xn;
    logic [ProdBits-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= r_sq_vld[SqrtSteps];
        end
        if (w_en) begin
            r_p_xn <= r_sq_xn[SqrtSteps];
            r_p    <= r_std * r_sq_root[SqrtSteps];
        end
    end

    // round half away from zero on the magnitude
    logic                 r_rd_vld, r_rd_xn;
    logic [RoundBits-1:0] r_rd;
    logic [ProdBits:0]    w_pr;
    assign w_pr = {1'b0, r_p} + (ProdBits+1)'(1 << 25);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (w_en) begin
            r_rd_vld <= r_p_vld;
        end
        if (w_en) begin
            r_rd_xn <= r_p_xn;
            r_rd    <= w_pr[26+RoundBits-1:26];
        end
    end

    // sign, mean, saturate into the output register
    logic signed [25:0] w_mag, w_tot;
    logic signed [OutBits-1:0] w_sat;
    assign w_mag = $signed({7'd0, r_rd});
    assign w_tot = (r_rd_xn ? -w_mag : w_mag) + 26'(r_mean);

    always_comb begin
        if (w_tot > 26'sd8388607) begin
            w_sat = 24'sh7FFFFF;
        end else if (w_tot < -26'sd8388608) begin
            w_sat = 24'sh800000;
        end else begin
            w_sat = w_tot[OutBits-1:0];
        end
    end

    logic r_out_vld;
    logic signed [OutBits-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_rd_vld;
        end
        if (w_en) begin
            r_out <= w_sat;
        end
    end

    // hold everything while a result waits on a stalled output
    assign w_en              = !(r_out_vld && i_stall);
    assign o_stall           = !w_en;
    assign o_valid           = r_out_vld;
    assign o_gaussian_sample = r_out;

endmodule
